>>> hw/rtl/pljos_pkg.sv
// ----------------------------------------------------------------------------
// pljos_pkg
// Types, sizes and codes shared by the positional list engine: item and
// result formats, cell commands, group summaries and controller states.
// ----------------------------------------------------------------------------
package pljos_pkg;

   localparam int CAPACITY = 128;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int GROUP    = 16;
   localparam int GRP_W    = $clog2(GROUP);
   localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;
   localparam int NPAD     = NGROUP * GROUP;
   localparam int SUM_W    = ((IDX_W > 8) ? IDX_W : 8) + 1;
   localparam int SCNT_W   = $clog2(SUM_W + 1);
   localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;
   localparam int CSR_ADDR_W = 3;

   localparam logic [2:0] MODE_INSERT     = 3'd0;
   localparam logic [2:0] MODE_DELETE     = 3'd1;
   localparam logic [2:0] MODE_LOCATE     = 3'd2;
   localparam logic [2:0] MODE_ELIM_FIRST = 3'd3;
   localparam logic [2:0] MODE_ELIM_NEXT  = 3'd4;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_BADPOS = 2'd2;
   localparam logic [1:0] STATUS_EMPTY  = 2'd3;

   localparam logic REG_STEP  = 1'b0;
   localparam logic REG_START = 1'b1;

   typedef struct packed {
      logic [2:0]               mode;
      logic [7:0]               position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [7:0]               found_position;
      logic signed [DATA_W-1:0] out_value;
      logic [7:0]               list_length;
   } rsp_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_MATCH,
      CELL_PICK
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [IDX_W-1:0]  tgt;
      logic [DATA_W-1:0] key;
      logic [CNT_W-1:0]  count;
   } cell_cmd_type;

   typedef struct packed {
      logic              hit;
      logic [GRP_W-1:0]  lidx;
      logic [DATA_W-1:0] value;
   } group_sum_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_REDUCE,
      ST_PICK,
      ST_GATHER,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/pljos_cell.sv
// ----------------------------------------------------------------------------
// pljos_cell
// One list entry. Shifts up or down with its neighbors, loads a new value,
// and flags a match or a selection against a broadcast command.
// ----------------------------------------------------------------------------
module pljos_cell import pljos_pkg::*; (
   input  logic              clock,
   input  cell_cmd_type      cmd,
   input  logic [IDX_W-1:0]  cell_index,
   input  logic [DATA_W-1:0] left_value,
   input  logic [DATA_W-1:0] right_value,
   output logic [DATA_W-1:0] value,
   output logic              hit
);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic              in_list;

   assign in_list = CNT_W'(cell_index) < cmd.count;

   always_comb begin
      value_in = value_ff;
      hit      = 1'b0;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (cell_index > cmd.tgt) begin
               value_in = left_value;
            end else if (cell_index == cmd.tgt) begin
               value_in = cmd.key;
            end
         end
         CELL_DELETE: begin
            if (cell_index >= cmd.tgt) begin
               value_in = right_value;
            end
         end
         CELL_MATCH: hit = in_list && (value_ff == cmd.key);
         CELL_PICK:  hit = (cell_index == cmd.tgt);
         default:    hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> hw/rtl/pljos_group.sv
// ----------------------------------------------------------------------------
// pljos_group
// Registered summary of one group of cells: any hit, the first hit's local
// index and the OR of the values of the hit cells.
// ----------------------------------------------------------------------------
module pljos_group import pljos_pkg::*; (
   input  logic                          clock,
   input  logic [GROUP-1:0]              hits,
   input  logic [GROUP-1:0][DATA_W-1:0]  values,
   output group_sum_type                 summary
);

   group_sum_type summary_ff;
   group_sum_type summary_in;

   always_comb begin
      summary_in.hit   = |hits;
      summary_in.lidx  = '0;
      summary_in.value = '0;
      for (int k = GROUP - 1; k >= 0; k--) begin
         if (hits[k]) begin
            summary_in.lidx = GRP_W'(k);
         end
      end
      for (int k = 0; k < GROUP; k++) begin
         summary_in.value = summary_in.value | (values[k] & {DATA_W{hits[k]}});
      end
   end

   always_ff @(posedge clock) begin
      summary_ff <= summary_in;
   end

   assign summary = summary_ff;

endmodule

>>> hw/rtl/pljos_mod.sv
// ----------------------------------------------------------------------------
// pljos_mod
// Restoring remainder unit: one numerator bit per cycle, done pulses in the
// cycle after the last step with the remainder held.
// ----------------------------------------------------------------------------
module pljos_mod import pljos_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  numer,
   input  logic [CNT_W-1:0]  denom,
   output logic              done,
   output logic [IDX_W-1:0]  rem
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SCNT_W-1:0] steps_ff, steps_in;
   logic [SUM_W-1:0]  numer_ff, numer_in;
   logic [CNT_W-1:0]  denom_ff, denom_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W:0]    trial;

   assign trial = {rem_ff, numer_ff[SUM_W-1]};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      steps_in = steps_ff;
      numer_in = numer_ff;
      denom_in = denom_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         steps_in = SCNT_W'(SUM_W);
         numer_in = numer;
         denom_in = denom;
         rem_in   = '0;
      end else if (busy_ff) begin
         numer_in = numer_ff << 1;
         steps_in = steps_ff - SCNT_W'(1);
         if (trial >= {1'b0, denom_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, denom_ff});
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         if (steps_ff == SCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         steps_ff <= steps_in;
      end
      numer_ff <= numer_in;
      denom_ff <= denom_in;
      rem_ff   <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff[IDX_W-1:0];

endmodule

>>> hw/rtl/positional_list_josephus_engine.sv
// ----------------------------------------------------------------------------
// positional_list_josephus_engine
// Bounded ordered list of signed 32-bit entries held in a row of cells, with
// insert, delete, locate and Josephus elimination.
//
//   channel | direction | handshake                 | payload
//   req     | in        | req_valid / req_stall     | req_data (mode, position, value)
//   rsp     | out       | rsp_valid / rsp_stall     | rsp_data (status, position, value, length)
//   csr     | in        | APB psel/penable/pready   | step_count @0x0, start_position @0x4
//
// Insert, delete and no-op items pass through DECODE and DONE, locate adds
// GATHER, and elimination of a non-empty list runs DECODE, REDUCE (held by
// the bit-serial remainder unit), PICK, GATHER and DONE. One item is in flight
// at a time; the result register lets the next item enter while a result
// waits. Reset is synchronous and empties the list without touching the
// cells. A stalled result holds the controller in its final state.
// ----------------------------------------------------------------------------
module positional_list_josephus_engine import pljos_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   state_type         state_ff, state_in;
   logic [2:0]        mode_ff, mode_in;
   logic [7:0]        pos_ff, pos_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  cursor_ff, cursor_in;
   logic [IDX_W-1:0]  tgt_ff, tgt_in;
   logic [1:0]        status_ff, status_in;
   logic [7:0]        found_ff, found_in;
   logic [DATA_W-1:0] outv_ff, outv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [7:0]        step_ff, step_in;
   logic [7:0]        start_ff, start_in;

   cell_cmd_type      cell_cmd;
   logic [NPAD-1:0]              cell_hit;
   logic [NPAD-1:0][DATA_W-1:0]  cell_val;
   group_sum_type     grp_sum [NGROUP];
   logic [NGROUP-1:0] grp_hit;

   logic              mod_start;
   logic              mod_done;
   logic [IDX_W-1:0]  mod_rem;
   logic [SUM_W-1:0]  mod_numer;

   logic              req_take;
   logic              slot_free;
   logic              csr_write;
   logic              is_insert, is_delete, is_locate, is_elim;
   logic              list_full, list_empty, ins_bad, del_bad;
   logic [7:0]        step_eff, start_eff;
   logic              sel_hit;
   logic [IDX_W-1:0]  sel_idx;
   logic [DATA_W-1:0] sel_val;

   // Cell row
   for (genvar j = 0; j < NPAD; j++) begin : g_cell
      if (j < CAPACITY) begin : g_live
         logic [DATA_W-1:0] left_v;
         logic [DATA_W-1:0] right_v;
         if (j == 0) begin : g_first
            assign left_v = cell_cmd.key;
         end else begin : g_mid_l
            assign left_v = cell_val[j-1];
         end
         if (j == CAPACITY - 1) begin : g_last
            assign right_v = '0;
         end else begin : g_mid_r
            assign right_v = cell_val[j+1];
         end
         pljos_cell u_cell (
            .clock       (clock),
            .cmd         (cell_cmd),
            .cell_index  (IDX_W'(j)),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_val[j]),
            .hit         (cell_hit[j])
         );
      end else begin : g_pad
         assign cell_val[j] = '0;
         assign cell_hit[j] = 1'b0;
      end
   end

   for (genvar g = 0; g < NGROUP; g++) begin : g_group
      pljos_group u_group (
         .clock   (clock),
         .hits    (cell_hit[g*GROUP +: GROUP]),
         .values  (cell_val[g*GROUP +: GROUP]),
         .summary (grp_sum[g])
      );
      assign grp_hit[g] = grp_sum[g].hit;
   end

   pljos_mod u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .numer (mod_numer),
      .denom (count_ff),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   // Decode
   assign req_take   = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign is_insert  = (mode_ff == MODE_INSERT);
   assign is_delete  = (mode_ff == MODE_DELETE);
   assign is_locate  = (mode_ff == MODE_LOCATE);
   assign is_elim    = (mode_ff == MODE_ELIM_FIRST) || (mode_ff == MODE_ELIM_NEXT);
   assign list_full  = (count_ff >= CNT_W'(CAPACITY));
   assign list_empty = (count_ff == '0);
   assign ins_bad    = (pos_ff == 8'd0) ||
                       (CMP_W'(pos_ff) > (CMP_W'(count_ff) + CMP_W'(1)));
   assign del_bad    = (pos_ff == 8'd0) || (CMP_W'(pos_ff) > CMP_W'(count_ff));
   assign step_eff   = (step_ff == 8'd0) ? 8'd1 : step_ff;
   assign start_eff  = (start_ff == 8'd0) ? 8'd1 : start_ff;

   always_comb begin
      if (mode_ff == MODE_ELIM_FIRST) begin
         mod_numer = SUM_W'(start_eff) - SUM_W'(1) + SUM_W'(step_eff) - SUM_W'(1);
      end else begin
         mod_numer = SUM_W'(cursor_ff) + SUM_W'(step_eff) - SUM_W'(1);
      end
   end

   always_comb begin
      sel_hit = 1'b0;
      sel_idx = '0;
      sel_val = '0;
      for (int g = NGROUP - 1; g >= 0; g--) begin
         if (grp_sum[g].hit) begin
            sel_hit = 1'b1;
            sel_idx = IDX_W'(g * GROUP + int'(grp_sum[g].lidx));
            sel_val = grp_sum[g].value;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (is_locate) begin
               state_in = ST_GATHER;
            end else if (is_elim && !list_empty) begin
               state_in = ST_REDUCE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_REDUCE: begin
            if (mod_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK:   state_in = ST_GATHER;
         ST_GATHER: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Controller outputs
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      mod_start      = 1'b0;
      cell_cmd.op    = CELL_HOLD;
      cell_cmd.tgt   = tgt_ff;
      cell_cmd.key   = key_ff;
      cell_cmd.count = count_ff;
      unique case (state_ff)
         ST_DECODE: begin
            if (is_insert && !list_full && !ins_bad) begin
               cell_cmd.op  = CELL_INSERT;
               cell_cmd.tgt = IDX_W'(pos_ff - 8'd1);
            end else if (is_delete && !del_bad) begin
               cell_cmd.op  = CELL_DELETE;
               cell_cmd.tgt = IDX_W'(pos_ff - 8'd1);
            end else if (is_locate) begin
               cell_cmd.op  = CELL_MATCH;
            end else if (is_elim && !list_empty) begin
               mod_start    = 1'b1;
            end
         end
         ST_PICK: cell_cmd.op = CELL_PICK;
         ST_GATHER: begin
            if (is_elim) begin
               cell_cmd.op = CELL_DELETE;
            end
         end
         default: cell_cmd.op = CELL_HOLD;
      endcase
   end

   // Datapath registers
   always_comb begin
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      tgt_in       = tgt_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      outv_in      = outv_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      step_in      = step_ff;
      start_in     = start_ff;

      if (req_take) begin
         mode_in = req_data.mode;
         pos_in  = req_data.position;
         key_in  = req_data.value;
      end

      unique case (state_ff)
         ST_DECODE: begin
            status_in = STATUS_OK;
            found_in  = 8'd0;
            outv_in   = '0;
            if (is_insert) begin
               if (list_full) begin
                  status_in = STATUS_FULL;
               end else if (ins_bad) begin
                  status_in = STATUS_BADPOS;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end else if (is_delete) begin
               if (del_bad) begin
                  status_in = STATUS_BADPOS;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end else if (is_elim && list_empty) begin
               status_in = STATUS_EMPTY;
            end
         end
         ST_REDUCE: begin
            if (mod_done) begin
               tgt_in = mod_rem;
            end
         end
         ST_GATHER: begin
            if (is_elim) begin
               found_in  = 8'(CNT_W'(tgt_ff) + CNT_W'(1));
               outv_in   = sel_val;
               count_in  = count_ff - CNT_W'(1);
               cursor_in = tgt_ff;
            end else if (sel_hit) begin
               found_in  = 8'(CNT_W'(sel_idx) + CNT_W'(1));
            end
         end
         default: begin
            tgt_in = tgt_ff;
         end
      endcase

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_DONE && slot_free) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = status_ff;
         rsp_in.found_position = found_ff;
         rsp_in.out_value      = outv_ff;
         rsp_in.list_length    = 8'(count_ff);
      end

      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_STEP:  step_in  = csr_pwdata[7:0];
            REG_START: start_in = csr_pwdata[7:0];
            default:   step_in  = step_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= 8'd1;
         start_ff     <= 8'd1;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         start_ff     <= start_in;
      end
      mode_ff   <= mode_in;
      pos_ff    <= pos_in;
      key_ff    <= key_in;
      tgt_ff    <= tgt_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      outv_ff   <= outv_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[2])
         REG_STEP:  csr_prdata = {24'd0, step_ff};
         REG_START: csr_prdata = {24'd0, start_ff};
         default:   csr_prdata = '0;
      endcase
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length beyond capacity");

   a_mod_done_state: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_REDUCE))
      else $error("remainder finished outside reduction");

   a_pick_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GATHER && is_elim) |-> ($countones(grp_hit) == 1))
      else $error("elimination selected other than one entry");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |->
         ($past(state_ff) == ST_DECODE || $past(state_ff) == ST_GATHER))
      else $error("list length changed outside an update");
`endif

endmodule

>>> tb/positional_list_josephus_engine_tb.sv
// ----------------------------------------------------------------------------
// positional_list_josephus_engine_tb
// Self-checking bench for the positional list engine. A directed table walks
// the empty and error cases, a fill to capacity probes the full list, then
// random phases with different step and start settings drive insert, delete,
// locate, elimination and unused-mode traffic. An in-bench list model predicts
// every result, compared field by field in order, with random idling on both
// channels and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module positional_list_josephus_engine_tb import pljos_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 66;
   localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VMIN = 32'sh8000_0000;
   localparam logic signed [31:0] VX   = 32'sh1234_5678;

   typedef struct packed {
      req_type item;
      logic    known;
      rsp_type want;
   } script_row_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // list model state
   logic signed [31:0] entries [CAPACITY] = '{default: '0};
   int unsigned        fill    = 0;
   int unsigned        cursor  = 0;
   logic [7:0]         step_cfg  = 8'd1;
   logic [7:0]         start_cfg = 8'd1;

   rsp_type list_outcomes [$];
   bit      pinned_valid = 1'b0;
   rsp_type pinned_rsp   = '0;
   bit      gaps_on      = 1'b1;
   bit      hold_off_req = 1'b0;
   int      errors       = 0;

   script_row_type script [25] = '{
      '{'{MODE_ELIM_NEXT,  8'd0,   32'sd0}, 1'b1, '{STATUS_EMPTY,  8'd0, 32'sd0, 8'd0}},
      '{'{MODE_ELIM_FIRST, 8'd0,   32'sd0}, 1'b1, '{STATUS_EMPTY,  8'd0, 32'sd0, 8'd0}},
      '{'{MODE_DELETE,     8'd1,   32'sd0}, 1'b1, '{STATUS_BADPOS, 8'd0, 32'sd0, 8'd0}},
      '{'{MODE_LOCATE,     8'd0,   32'sd0}, 1'b1, '{STATUS_OK,     8'd0, 32'sd0, 8'd0}},
      '{'{MODE_INSERT,     8'd0,   32'sd7}, 1'b1, '{STATUS_BADPOS, 8'd0, 32'sd0, 8'd0}},
      '{'{MODE_INSERT,     8'd2,   32'sd7}, 1'b1, '{STATUS_BADPOS, 8'd0, 32'sd0, 8'd0}},
      '{'{MODE_INSERT,     8'd1,   VMAX},   1'b1, '{STATUS_OK,     8'd0, 32'sd0, 8'd1}},
      '{'{MODE_INSERT,     8'd2,   VMIN},   1'b1, '{STATUS_OK,     8'd0, 32'sd0, 8'd2}},
      '{'{MODE_INSERT,     8'd1,   -32'sd1},1'b1, '{STATUS_OK,     8'd0, 32'sd0, 8'd3}},
      '{'{MODE_INSERT,     8'd255, 32'sd5}, 1'b1, '{STATUS_BADPOS, 8'd0, 32'sd0, 8'd3}},
      '{'{MODE_LOCATE,     8'd0,   VMIN},   1'b1, '{STATUS_OK,     8'd3, 32'sd0, 8'd3}},
      '{'{MODE_LOCATE,     8'd0,   32'sd0}, 1'b1, '{STATUS_OK,     8'd0, 32'sd0, 8'd3}},
      '{'{3'd5,            8'd1,   VMAX},   1'b1, '{STATUS_OK,     8'd0, 32'sd0, 8'd3}},
      '{'{3'd6,            8'd255, -32'sd1},1'b1, '{STATUS_OK,     8'd0, 32'sd0, 8'd3}},
      '{'{3'd7,            8'd0,   VMIN},   1'b1, '{STATUS_OK,     8'd0, 32'sd0, 8'd3}},
      '{'{MODE_ELIM_NEXT,  8'd0,   32'sd0}, 1'b1, '{STATUS_OK,     8'd1, -32'sd1, 8'd2}},
      '{'{MODE_DELETE,     8'd3,   32'sd0}, 1'b1, '{STATUS_BADPOS, 8'd0, 32'sd0, 8'd2}},
      '{'{MODE_DELETE,     8'd0,   32'sd0}, 1'b1, '{STATUS_BADPOS, 8'd0, 32'sd0, 8'd2}},
      '{'{MODE_INSERT,     8'd3,   VX},     1'b1, '{STATUS_OK,     8'd0, 32'sd0, 8'd3}},
      '{'{MODE_LOCATE,     8'd0,   -32'sd1},1'b0, '0},
      '{'{MODE_DELETE,     8'd1,   32'sd0}, 1'b1, '{STATUS_OK,     8'd0, 32'sd0, 8'd2}},
      '{'{MODE_ELIM_FIRST, 8'd0,   32'sd0}, 1'b1, '{STATUS_OK,     8'd1, VMIN,   8'd1}},
      '{'{MODE_INSERT,     8'd1,   32'sd0}, 1'b0, '0},
      '{'{MODE_ELIM_NEXT,  8'd0,   32'sd0}, 1'b0, '0},
      '{'{MODE_ELIM_NEXT,  8'd0,   32'sd0}, 1'b1, '{STATUS_OK,     8'd1, VX,     8'd0}}
   };

   positional_list_josephus_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("positional_list_josephus_engine_tb NOT OK");
      $finish;
   end

   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, label, want, got);
         errors++;
      end
   endfunction

   function automatic void drop_entry(input int unsigned idx);
      for (int unsigned j = idx + 1; j < fill; j++) entries[j-1] = entries[j];
      fill--;
   endfunction

   function automatic rsp_type apply_list_op(input req_type item);
      rsp_type     r;
      int unsigned m;
      int unsigned s;
      int unsigned idx;
      r = '0;
      case (item.mode)
         MODE_INSERT: begin
            if (fill >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else if (item.position < 1 || item.position > fill + 1) begin
               r.status = STATUS_BADPOS;
            end else begin
               for (int j = fill; j >= item.position; j--) entries[j] = entries[j-1];
               entries[item.position-1] = item.value;
               fill++;
            end
         end
         MODE_DELETE: begin
            if (item.position < 1 || item.position > fill) r.status = STATUS_BADPOS;
            else drop_entry(item.position - 1);
         end
         MODE_LOCATE: begin
            for (int unsigned j = 0; j < fill && r.found_position == 0; j++)
               if (entries[j] == item.value) r.found_position = 8'(j + 1);
         end
         MODE_ELIM_FIRST, MODE_ELIM_NEXT: begin
            if (fill == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               m = (step_cfg == 0) ? 1 : step_cfg;
               s = (start_cfg == 0) ? 1 : start_cfg;
               if (item.mode == MODE_ELIM_FIRST) cursor = s - 1;
               idx = (cursor + m - 1) % fill;
               r.found_position = 8'(idx + 1);
               r.out_value = entries[idx];
               drop_entry(idx);
               cursor = idx;
            end
         end
         default: begin
         end
      endcase
      r.list_length = 8'(fill);
      return r;
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(3))
         0: return 32'($urandom_range(15)) - 32'sd8;
         1: return $urandom;
         2: return (fill > 0) ? entries[$urandom_range(fill - 1)] : $urandom;
         default: begin
            case ($urandom_range(3))
               0: return VMIN;
               1: return VMAX;
               2: return -32'sd1;
               default: return 32'sd0;
            endcase
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type want;
      if (!reset && req_valid && !req_stall) begin
         predicted = apply_list_op(req_data);
         list_outcomes.push_back(pinned_valid ? pinned_rsp : predicted);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (list_outcomes.size() == 0) begin
            $display("%0t: unexpected transfer, expected none got %0h", $time, rsp_data);
            errors++;
         end else begin
            want = list_outcomes.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("found_position", 32'(want.found_position),
                        32'(rsp_data.found_position));
            check_field("out_value", want.out_value, rsp_data.out_value);
            check_field("list_length", 32'(want.list_length), 32'(rsp_data.list_length));
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_stall <= gaps_on && ($urandom_range(99) < 34);
         end
      end
   end

   task automatic offer(input req_type item, input bit known, input rsp_type want);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      pinned_valid = known;
      pinned_rsp   = want;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (list_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic csr_update(input logic idx, input logic [7:0] val);
      logic [31:0] rd;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'($urandom), val};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_STEP) step_cfg = val;
      else start_cfg = val;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      check_field("register readback", 32'(val), 32'(rd[7:0]));
   endtask

   initial begin
      req_type     item;
      int          pick;
      int unsigned n;
      logic [7:0]  stp;
      logic [7:0]  sta;
      logic [7:0]  step_plan  [5];
      logic [7:0]  start_plan [5];
      logic [7:0]  full_probe [4];

      step_plan  = '{8'd3, 8'd0, 8'd1, 8'd128, 8'd7};
      start_plan = '{8'd2, 8'd0, 8'd128, 8'd1, 8'd5};
      full_probe = '{8'd0, 8'd1, 8'd129, 8'd255};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) offer(script[i].item, script[i].known, script[i].want);

      // fill to capacity, probe the full list, then eliminate it down to empty
      settle();
      csr_update(REG_STEP, 8'd128);
      csr_update(REG_START, 8'd128);
      n = fill;
      while (n < CAPACITY) begin
         item = '{MODE_INSERT, 8'($urandom_range(n + 1, 1)), pick_value()};
         offer(item, 1'b0, '0);
         n++;
      end
      foreach (full_probe[i]) offer('{MODE_INSERT, full_probe[i], $urandom}, 1'b0, '0);
      offer('{MODE_DELETE, 8'd129, 32'sd0}, 1'b0, '0);
      hold_off_req = 1'b1;
      offer('{MODE_ELIM_FIRST, 8'($urandom), $urandom}, 1'b0, '0);
      repeat (CAPACITY) offer('{MODE_ELIM_NEXT, 8'($urandom), $urandom}, 1'b0, '0);

      for (int p = 0; p < 7; p++) begin
         settle();
         stp = (p < 5) ? step_plan[p]  : 8'($urandom_range(128, 1));
         sta = (p < 5) ? start_plan[p] : 8'($urandom_range(128, 1));
         gaps_on = (p != 2);
         csr_update(REG_STEP, stp);
         csr_update(REG_START, sta);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(99);
            if (pick < 45)      item.mode = MODE_INSERT;
            else if (pick < 57) item.mode = MODE_DELETE;
            else if (pick < 72) item.mode = MODE_LOCATE;
            else if (pick < 78) item.mode = MODE_ELIM_FIRST;
            else if (pick < 93) item.mode = MODE_ELIM_NEXT;
            else                item.mode = 3'($urandom_range(7, 5));
            item.position = ($urandom_range(99) < 85) ? 8'($urandom_range(fill + 1, 1))
                                                      : 8'($urandom_range(255));
            item.value = pick_value();
            offer(item, 1'b0, '0);
         end
      end
      gaps_on = 1'b1;

      settle();
      repeat (40) @(posedge clock);
      if (errors == 0) $display("positional_list_josephus_engine_tb OK");
      else $display("positional_list_josephus_engine_tb NOT OK");
      $finish;
   end

endmodule

>>> positional_list_josephus_engine.f
hw/rtl/pljos_pkg.sv
hw/rtl/pljos_cell.sv
hw/rtl/pljos_group.sv
hw/rtl/pljos_mod.sv
hw/rtl/positional_list_josephus_engine.sv
tb/positional_list_josephus_engine_tb.sv
